FILE: rtl/a2km_pkg.sv
package a2km_pkg;

  // Matrix geometry.
  localparam int unsigned ROWS     = 8;
  localparam int unsigned COLS     = 5;
  localparam int unsigned MATRIX_W = ROWS * COLS;
  localparam int unsigned POS_W    = $clog2(MATRIX_W);

  // Host codes with special handling.
  localparam logic [7:0] KEY_BS     = 8'd8;
  localparam logic [7:0] KEY_LF     = 8'd10;
  localparam logic [7:0] KEY_CR     = 8'd13;
  localparam logic [7:0] KEY_ESC    = 8'd27;
  localparam logic [7:0] KEY_DEL    = 8'd127;
  localparam logic [7:0] KEY_UPPER_A = 8'h41;
  localparam logic [7:0] KEY_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_OFFSET = 8'd32;

  // Fixed matrix positions, as row * COLS + column.
  localparam logic [POS_W-1:0] CAPS_POS  = POS_W'(0 * COLS + 0);
  localparam logic [POS_W-1:0] SYM_POS   = POS_W'(7 * COLS + 1);
  localparam logic [POS_W-1:0] ENTER_POS = POS_W'(6 * COLS + 0);
  localparam logic [POS_W-1:0] ZERO_POS  = POS_W'(4 * COLS + 0);

  // Two-entry queues on both sides of the back end.
  localparam int unsigned     QUEUE_DEPTH = 2;
  localparam int unsigned     QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned     QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam logic [QCNT_W-1:0] QUEUE_FULL_CNT = QCNT_W'(QUEUE_DEPTH);

  typedef struct packed {
    logic       func;
    logic [7:0] key_code;
    logic       is_press;
    logic       ctrl_held;
  } in_item_t;

  typedef struct packed {
    logic [MATRIX_W-1:0] matrix_bits;
    logic                was_mapped;
  } out_item_t;

  // Command handed from the decoder to the matrix update stage.
  typedef struct packed {
    logic                clear;
    logic                down;
    logic                mapped;
    logic [MATRIX_W-1:0] mask;
  } cmd_t;

  // Table entry: bit 7 valid, bit 6 needs symbol shift, bits 5..3 row, bits 2..0 column.
  function automatic logic [7:0] ke(input logic [2:0] row, input logic [2:0] col);
    ke = {2'b10, row, col};
  endfunction

  function automatic logic [7:0] ks(input logic [2:0] row, input logic [2:0] col);
    ks = {2'b11, row, col};
  endfunction

  function automatic logic [7:0] key_lut(input logic [6:0] code);
    unique case (code)
      7'h20: key_lut = ke(3'd7, 3'd0);
      7'h30: key_lut = ke(3'd4, 3'd0);
      7'h31: key_lut = ke(3'd3, 3'd0);
      7'h32: key_lut = ke(3'd3, 3'd1);
      7'h33: key_lut = ke(3'd3, 3'd2);
      7'h34: key_lut = ke(3'd3, 3'd3);
      7'h35: key_lut = ke(3'd3, 3'd4);
      7'h36: key_lut = ke(3'd4, 3'd4);
      7'h37: key_lut = ke(3'd4, 3'd3);
      7'h38: key_lut = ke(3'd4, 3'd2);
      7'h39: key_lut = ke(3'd4, 3'd1);
      7'h61: key_lut = ke(3'd1, 3'd0);
      7'h62: key_lut = ke(3'd7, 3'd4);
      7'h63: key_lut = ke(3'd0, 3'd3);
      7'h64: key_lut = ke(3'd1, 3'd2);
      7'h65: key_lut = ke(3'd2, 3'd2);
      7'h66: key_lut = ke(3'd1, 3'd3);
      7'h67: key_lut = ke(3'd1, 3'd4);
      7'h68: key_lut = ke(3'd6, 3'd4);
      7'h69: key_lut = ke(3'd5, 3'd2);
      7'h6A: key_lut = ke(3'd6, 3'd3);
      7'h6B: key_lut = ke(3'd6, 3'd2);
      7'h6C: key_lut = ke(3'd6, 3'd1);
      7'h6D: key_lut = ke(3'd7, 3'd2);
      7'h6E: key_lut = ke(3'd7, 3'd3);
      7'h6F: key_lut = ke(3'd5, 3'd1);
      7'h70: key_lut = ke(3'd5, 3'd0);
      7'h71: key_lut = ke(3'd2, 3'd0);
      7'h72: key_lut = ke(3'd2, 3'd3);
      7'h73: key_lut = ke(3'd1, 3'd1);
      7'h74: key_lut = ke(3'd2, 3'd4);
      7'h75: key_lut = ke(3'd5, 3'd3);
      7'h76: key_lut = ke(3'd0, 3'd4);
      7'h77: key_lut = ke(3'd2, 3'd1);
      7'h78: key_lut = ke(3'd0, 3'd2);
      7'h79: key_lut = ke(3'd5, 3'd4);
      7'h7A: key_lut = ke(3'd0, 3'd1);
      7'h21: key_lut = ks(3'd3, 3'd0);
      7'h22: key_lut = ks(3'd5, 3'd0);
      7'h23: key_lut = ks(3'd3, 3'd2);
      7'h24: key_lut = ks(3'd3, 3'd3);
      7'h25: key_lut = ks(3'd3, 3'd4);
      7'h26: key_lut = ks(3'd4, 3'd4);
      7'h27: key_lut = ks(3'd4, 3'd3);
      7'h28: key_lut = ks(3'd4, 3'd2);
      7'h29: key_lut = ks(3'd4, 3'd1);
      7'h2A: key_lut = ks(3'd7, 3'd4);
      7'h2B: key_lut = ks(3'd6, 3'd2);
      7'h2C: key_lut = ks(3'd7, 3'd3);
      7'h2D: key_lut = ks(3'd6, 3'd3);
      7'h2E: key_lut = ks(3'd7, 3'd2);
      7'h2F: key_lut = ks(3'd0, 3'd4);
      7'h3A: key_lut = ks(3'd0, 3'd1);
      7'h3B: key_lut = ks(3'd5, 3'd1);
      7'h3C: key_lut = ks(3'd2, 3'd3);
      7'h3D: key_lut = ks(3'd6, 3'd1);
      7'h3E: key_lut = ks(3'd2, 3'd4);
      7'h3F: key_lut = ks(3'd0, 3'd3);
      7'h40: key_lut = ks(3'd3, 3'd1);
      7'h5B: key_lut = ks(3'd5, 3'd4);
      7'h5C: key_lut = ks(3'd1, 3'd2);
      7'h5D: key_lut = ks(3'd5, 3'd3);
      7'h5E: key_lut = ks(3'd6, 3'd4);
      7'h5F: key_lut = ks(3'd4, 3'd0);
      7'h60: key_lut = ks(3'd0, 3'd2);
      7'h7B: key_lut = ks(3'd1, 3'd3);
      7'h7C: key_lut = ks(3'd1, 3'd1);
      7'h7D: key_lut = ks(3'd1, 3'd4);
      7'h7E: key_lut = ks(3'd1, 3'd0);
      default: key_lut = 8'h00;
    endcase
  endfunction

  // One-hot mask for a matrix position.
  function automatic logic [MATRIX_W-1:0] pos_mask(input logic [POS_W-1:0] pos);
    logic [MATRIX_W-1:0] m;
    m = '0;
    for (int i = 0; i < MATRIX_W; i++) begin
      m[i] = (pos == POS_W'(i));
    end
    pos_mask = m;
  endfunction

endpackage

FILE: rtl/a2km_front.sv
module a2km_front (
  input  a2km_pkg::in_item_t in_item,
  input  logic               push,
  input  logic               q_full,
  output logic               full,
  output logic               q_push,
  output a2km_pkg::cmd_t     q_cmd
);

  logic                            ignore;
  logic                            upper;
  logic [7:0]                      lc_code;
  logic [7:0]                      entry;
  logic [a2km_pkg::POS_W-1:0]      key_pos;
  logic [a2km_pkg::MATRIX_W-1:0]   key_mask;

  assign full   = q_full;
  assign q_push = push && !q_full;

  assign ignore  = in_item.ctrl_held || in_item.key_code[7] ||
                   (in_item.key_code == a2km_pkg::KEY_ESC);
  assign upper   = (in_item.key_code >= a2km_pkg::KEY_UPPER_A) &&
                   (in_item.key_code <= a2km_pkg::KEY_UPPER_Z);
  assign lc_code = upper ? (in_item.key_code + a2km_pkg::CASE_OFFSET) : in_item.key_code;
  assign entry   = a2km_pkg::key_lut(lc_code[6:0]);
  // Row times five plus column; the row term stays well inside six bits.
  assign key_pos = a2km_pkg::POS_W'({entry[5:3], 2'b00}) +
                   a2km_pkg::POS_W'(entry[5:3]) + a2km_pkg::POS_W'(entry[2:0]);

  always_comb begin
    key_mask = '0;
    if (entry[7]) begin
      key_mask = a2km_pkg::pos_mask(key_pos);
      if (entry[6]) begin
        key_mask = key_mask | a2km_pkg::pos_mask(a2km_pkg::SYM_POS);
      end
    end
    if (upper) begin
      key_mask = key_mask | a2km_pkg::pos_mask(a2km_pkg::CAPS_POS);
    end
  end

  always_comb begin
    q_cmd        = '0;
    q_cmd.down   = in_item.is_press;
    priority if (in_item.func) begin
      q_cmd.clear = 1'b1;
    end else if (ignore) begin
      q_cmd.mapped = 1'b0;
    end else if ((in_item.key_code == a2km_pkg::KEY_CR) ||
                 (in_item.key_code == a2km_pkg::KEY_LF)) begin
      q_cmd.mask   = a2km_pkg::pos_mask(a2km_pkg::ENTER_POS);
      q_cmd.mapped = 1'b1;
    end else if ((in_item.key_code == a2km_pkg::KEY_BS) ||
                 (in_item.key_code == a2km_pkg::KEY_DEL)) begin
      q_cmd.mask   = a2km_pkg::pos_mask(a2km_pkg::CAPS_POS) |
                     a2km_pkg::pos_mask(a2km_pkg::ZERO_POS);
      q_cmd.mapped = 1'b1;
    end else begin
      q_cmd.mask   = key_mask;
      q_cmd.mapped = entry[7];
    end
  end

endmodule

FILE: rtl/a2km_cmd_q.sv
module a2km_cmd_q (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_push,
  input  a2km_pkg::cmd_t q_cmd,
  output logic           q_full,
  input  logic           q_pop,
  output logic           q_valid,
  output a2km_pkg::cmd_t q_head
);

  a2km_pkg::cmd_t                 slot_r [a2km_pkg::QUEUE_DEPTH];
  logic [a2km_pkg::QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [a2km_pkg::QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [a2km_pkg::QCNT_W-1:0]    cnt_r, cnt_nxt;
  logic                           do_pop;

  assign q_full  = (cnt_r == a2km_pkg::QUEUE_FULL_CNT);
  assign q_valid = (cnt_r != '0);
  assign q_head  = slot_r[rd_ptr_r];
  assign do_pop  = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = q_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + a2km_pkg::QCNT_W'(q_push) - a2km_pkg::QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      slot_r[wr_ptr_r] <= q_cmd;
    end
  end

endmodule

FILE: rtl/a2km_back.sv
module a2km_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  a2km_pkg::cmd_t      q_head,
  output logic                q_pop,
  output logic                empty,
  input  logic                pop,
  output a2km_pkg::out_item_t out_item
);

  logic [a2km_pkg::MATRIX_W-1:0]  matrix_r, matrix_nxt;
  a2km_pkg::out_item_t            res_r [a2km_pkg::QUEUE_DEPTH];
  logic [a2km_pkg::QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [a2km_pkg::QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [a2km_pkg::QCNT_W-1:0]    cnt_r, cnt_nxt;
  logic                           res_full;
  logic                           do_out;
  a2km_pkg::out_item_t            res_new;

  assign res_full = (cnt_r == a2km_pkg::QUEUE_FULL_CNT);
  assign empty    = (cnt_r == '0);
  assign out_item = res_r[rd_ptr_r];
  assign q_pop    = q_valid && !res_full;
  assign do_out   = pop && !empty;

  always_comb begin
    priority if (q_head.clear) begin
      matrix_nxt = '0;
    end else if (q_head.down) begin
      matrix_nxt = matrix_r | q_head.mask;
    end else begin
      matrix_nxt = matrix_r & ~q_head.mask;
    end
    res_new.matrix_bits = matrix_nxt;
    res_new.was_mapped  = q_head.mapped;
    wr_ptr_nxt = q_pop ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_out ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + a2km_pkg::QCNT_W'(q_pop) - a2km_pkg::QCNT_W'(do_out);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      matrix_r <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (q_pop) begin
        matrix_r <= matrix_nxt;
      end
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res_r[wr_ptr_r] <= res_new;
    end
  end

endmodule

FILE: rtl/ascii_to_key_matrix.sv
// Channel   | Ports                          | Transaction when
// ----------+--------------------------------+---------------------------
// input     | push, full, in_item            | push high and full low
// result    | empty, pop, out_item           | pop high and empty low
//
// One transaction per cycle is sustained in both directions while results are popped
// as they appear. An accepted event is registered in the command queue, then its
// result is registered in the result queue, from which it can be popped.
// Reset (rst_n low, synchronous) clears the matrix and empties both queues.
// A stalled result side fills the result queue, then the command queue, and only
// then raises full; the decoder and the matrix update stall independently.
module ascii_to_key_matrix (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  a2km_pkg::in_item_t  in_item,
  output logic                empty,
  input  logic                pop,
  output a2km_pkg::out_item_t out_item
);

  // Decoder output into the command queue.
  logic           q_push;
  a2km_pkg::cmd_t q_cmd;
  logic           q_full;

  // Command queue head, consumed by the matrix update stage.
  logic           q_valid;
  logic           q_pop;
  a2km_pkg::cmd_t q_head;

  // The front end turns each host event into a set/clear mask over the
  // 40 matrix bits, including the caps and symbol shift keys it implies.
  a2km_front u_front (
    .in_item (in_item),
    .push    (push),
    .q_full  (q_full),
    .full    (full),
    .q_push  (q_push),
    .q_cmd   (q_cmd)
  );

  // A short queue decouples decoding from the matrix update.
  a2km_cmd_q u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (q_push),
    .q_cmd   (q_cmd),
    .q_full  (q_full),
    .q_pop   (q_pop),
    .q_valid (q_valid),
    .q_head  (q_head)
  );

  // The back end holds the matrix, applies each command and queues the
  // whole matrix with the mapped flag as the result.
  a2km_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

endmodule
